### rtl/hss_pkg.sv
// Shared types, constants and tables of the HMAC-SHA-256 stream block.
package hss_pkg;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_GO_OPAD,
      ST_BYTE,
      ST_PAD,
      ST_LEN_HI,
      ST_LEN_LO,
      ST_GO_OUTER,
      ST_C_INIT,
      ST_C_LOAD,
      ST_C_ROUND,
      ST_C_FINAL,
      ST_OUT_RD,
      ST_OUT_WAIT
   } state_type;

   typedef enum logic [1:0] {
      SRC_BUF,
      SRC_IPAD,
      SRC_OPAD,
      SRC_OUTER
   } blk_src_type;

   // Regions of the state memory, eight words each.
   localparam logic [1:0] REG_INNER   = 2'd0;
   localparam logic [1:0] REG_OUTER   = 2'd1;
   localparam logic [1:0] REG_CHAIN   = 2'd2;
   localparam logic [1:0] REG_SCRATCH = 2'd3;

   localparam logic [31:0] IPAD_WORD  = 32'h36363636;
   localparam logic [31:0] OPAD_WORD  = 32'h5c5c5c5c;
   localparam logic [31:0] PAD_MARK   = 32'h80000000;
   // Bit length of the outer message: key block plus inner digest.
   localparam logic [31:0] OUTER_BITS = 32'd768;
   localparam int unsigned KEY_REGS   = 8;

   typedef struct packed {
      logic        wk_shift;
      logic        w_shift;
      logic        round;
      logic [5:0]  round_idx;
      logic [31:0] din;
   } cmp_ctrl_type;

   function automatic logic [31:0] iv_word(input logic [2:0] idx);
      logic [31:0] r;
      case (idx)
         3'd0: r = 32'h6a09e667;
         3'd1: r = 32'hbb67ae85;
         3'd2: r = 32'h3c6ef372;
         3'd3: r = 32'ha54ff53a;
         3'd4: r = 32'h510e527f;
         3'd5: r = 32'h9b05688c;
         3'd6: r = 32'h1f83d9ab;
         default: r = 32'h5be0cd19;
      endcase
      return r;
   endfunction

   function automatic logic [31:0] round_const(input logic [5:0] idx);
      logic [31:0] r;
      case (idx)
         6'd0: r = 32'h428a2f98;  6'd1: r = 32'h71374491;
         6'd2: r = 32'hb5c0fbcf;  6'd3: r = 32'he9b5dba5;
         6'd4: r = 32'h3956c25b;  6'd5: r = 32'h59f111f1;
         6'd6: r = 32'h923f82a4;  6'd7: r = 32'hab1c5ed5;
         6'd8: r = 32'hd807aa98;  6'd9: r = 32'h12835b01;
         6'd10: r = 32'h243185be; 6'd11: r = 32'h550c7dc3;
         6'd12: r = 32'h72be5d74; 6'd13: r = 32'h80deb1fe;
         6'd14: r = 32'h9bdc06a7; 6'd15: r = 32'hc19bf174;
         6'd16: r = 32'he49b69c1; 6'd17: r = 32'hefbe4786;
         6'd18: r = 32'h0fc19dc6; 6'd19: r = 32'h240ca1cc;
         6'd20: r = 32'h2de92c6f; 6'd21: r = 32'h4a7484aa;
         6'd22: r = 32'h5cb0a9dc; 6'd23: r = 32'h76f988da;
         6'd24: r = 32'h983e5152; 6'd25: r = 32'ha831c66d;
         6'd26: r = 32'hb00327c8; 6'd27: r = 32'hbf597fc7;
         6'd28: r = 32'hc6e00bf3; 6'd29: r = 32'hd5a79147;
         6'd30: r = 32'h06ca6351; 6'd31: r = 32'h14292967;
         6'd32: r = 32'h27b70a85; 6'd33: r = 32'h2e1b2138;
         6'd34: r = 32'h4d2c6dfc; 6'd35: r = 32'h53380d13;
         6'd36: r = 32'h650a7354; 6'd37: r = 32'h766a0abb;
         6'd38: r = 32'h81c2c92e; 6'd39: r = 32'h92722c85;
         6'd40: r = 32'ha2bfe8a1; 6'd41: r = 32'ha81a664b;
         6'd42: r = 32'hc24b8b70; 6'd43: r = 32'hc76c51a3;
         6'd44: r = 32'hd192e819; 6'd45: r = 32'hd6990624;
         6'd46: r = 32'hf40e3585; 6'd47: r = 32'h106aa070;
         6'd48: r = 32'h19a4c116; 6'd49: r = 32'h1e376c08;
         6'd50: r = 32'h2748774c; 6'd51: r = 32'h34b0bcb5;
         6'd52: r = 32'h391c0cb3; 6'd53: r = 32'h4ed8aa4a;
         6'd54: r = 32'h5b9cca4f; 6'd55: r = 32'h682e6ff3;
         6'd56: r = 32'h748f82ee; 6'd57: r = 32'h78a5636f;
         6'd58: r = 32'h84c87814; 6'd59: r = 32'h8cc70208;
         6'd60: r = 32'h90befffa; 6'd61: r = 32'ha4506ceb;
         6'd62: r = 32'hbef9a3f7;
         default: r = 32'hc67178f2;
      endcase
      return r;
   endfunction

endpackage

### rtl/hss_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
module hss_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/hss_compress.sv
// SHA-256 working variables and message schedule window, one round per cycle.
module hss_compress
   import hss_pkg::*;
(
   input  logic         clock,
   input  cmp_ctrl_type ctrl,
   output logic [31:0]  a_val
);

   logic [31:0] wk_ff [8];
   logic [31:0] wk_in [8];
   logic [31:0] w_ff  [16];
   logic [31:0] w_in  [16];
   logic [31:0] s0, s1, w_new, big_s1, big_s0, ch, maj, t1, t2;

   always_comb begin
      // Window holds W[i] .. W[i+15]; w_new is W[i+16].
      s0 = {w_ff[1][6:0], w_ff[1][31:7]} ^ {w_ff[1][17:0], w_ff[1][31:18]}
         ^ (w_ff[1] >> 3);
      s1 = {w_ff[14][16:0], w_ff[14][31:17]} ^ {w_ff[14][18:0], w_ff[14][31:19]}
         ^ (w_ff[14] >> 10);
      w_new = w_ff[0] + s0 + w_ff[9] + s1;

      big_s1 = {wk_ff[4][5:0], wk_ff[4][31:6]} ^ {wk_ff[4][10:0], wk_ff[4][31:11]}
             ^ {wk_ff[4][24:0], wk_ff[4][31:25]};
      ch     = (wk_ff[4] & wk_ff[5]) ^ (~wk_ff[4] & wk_ff[6]);
      t1     = wk_ff[7] + big_s1 + ch + round_const(ctrl.round_idx) + w_ff[0];
      big_s0 = {wk_ff[0][1:0], wk_ff[0][31:2]} ^ {wk_ff[0][12:0], wk_ff[0][31:13]}
             ^ {wk_ff[0][21:0], wk_ff[0][31:22]};
      maj    = (wk_ff[0] & wk_ff[1]) ^ (wk_ff[0] & wk_ff[2]) ^ (wk_ff[1] & wk_ff[2]);
      t2     = big_s0 + maj;

      for (int i = 0; i < 8; i++) begin
         wk_in[i] = wk_ff[i];
      end
      for (int i = 0; i < 16; i++) begin
         w_in[i] = w_ff[i];
      end

      if (ctrl.wk_shift) begin
         for (int i = 0; i < 7; i++) begin
            wk_in[i] = wk_ff[i+1];
         end
         wk_in[7] = ctrl.din;
      end else if (ctrl.round) begin
         wk_in[7] = wk_ff[6];
         wk_in[6] = wk_ff[5];
         wk_in[5] = wk_ff[4];
         wk_in[4] = wk_ff[3] + t1;
         wk_in[3] = wk_ff[2];
         wk_in[2] = wk_ff[1];
         wk_in[1] = wk_ff[0];
         wk_in[0] = t1 + t2;
      end

      if (ctrl.w_shift || ctrl.round) begin
         for (int i = 0; i < 15; i++) begin
            w_in[i] = w_ff[i+1];
         end
         w_in[15] = ctrl.w_shift ? ctrl.din : w_new;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < 8; i++) begin
         wk_ff[i] <= wk_in[i];
      end
      for (int i = 0; i < 16; i++) begin
         w_ff[i] <= w_in[i];
      end
   end

   assign a_val = wk_ff[0];

endmodule

### rtl/hmac_sha256_stream.sv
// Top level of the HMAC-SHA-256 stream block: sequencer, key registers, memories.
//
// Message words enter on the req_ channel, 32 bits big-endian with a count of
// valid leading bytes (above four counts as four) and a last flag. The key is
// written as eight 64-bit registers on the csr_ channel; the user must write it
// only while idle, as the block does not enforce this. Any key write makes the
// next beat first hash both key pad blocks. Bytes of a beat enter the block
// buffer one byte per cycle, except while a full block is compressed. Each
// completed 64-byte block goes through the shared compression unit: 8 state
// reads and 16 schedule loads, each through a registered memory read, 64
// rounds, then 8 write-backs behind a registered read. Key pad setup costs
// two such compressions on the first beat after reset or a key write.
// On a last beat the block pads the message byte by byte, runs one or two inner
// compressions and one outer compression, then emits the eight digest words
// on the rsp_ channel, index 0 first, one beat at a time. A stalled
// receiver simply holds the block in its output state. Reset clears the
// control state and marks the key pads as not yet hashed; the memories are
// not cleared.
module hmac_sha256_stream
   import hss_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [31:0] req_msg_word,
   input  logic [2:0]  req_valid_bytes,
   input  logic        req_last_word,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_digest_word,
   output logic [2:0]  rsp_digest_index,
   output logic        rsp_digest_last,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [3:0]  csr_index,
   input  logic [63:0] csr_data
);

   state_type   state_ff, state_in, ret_ff, ret_in;
   blk_src_type src_ff, src_in;
   logic [1:0]  src_reg_ff, src_reg_in, dst_reg_ff, dst_reg_in;
   logic        use_iv_ff, use_iv_in;
   logic [6:0]  cnt_ff, cnt_in;
   logic [2:0]  bcnt_ff, bcnt_in;
   logic [2:0]  nbytes_ff, nbytes_in;
   logic        last_ff, last_in;
   logic [31:0] msg_ff, msg_in;
   logic [31:0] pw_ff, pw_in;
   logic [5:0]  fill_ff, fill_in;
   logic [63:0] len_ff, len_in;
   logic        pads_ff, pads_in;
   logic        fresh_ff, fresh_in;
   logic        pad_first_ff, pad_first_in;
   logic [63:0] key_ff [KEY_REGS];

   logic        req_fire, put, blk_full, pad_done;
   logic [7:0]  put_byte;
   logic [31:0] pw_new, key_word;
   logic [3:0]  load_idx;
   logic [2:0]  fin_idx;

   logic        st_wr_en, st_rd_en, buf_wr_en, buf_rd_en;
   logic [4:0]  st_wr_addr, st_rd_addr;
   logic [3:0]  buf_wr_addr, buf_rd_addr;
   logic [31:0] st_wr_data, st_rd_data, buf_wr_data, buf_rd_data;
   logic [31:0] a_val;
   cmp_ctrl_type ctrl;

   assign req_ready = (state_ff == ST_IDLE);
   assign csr_ready = 1'b1;
   assign req_fire  = req_valid && req_ready;
   assign load_idx  = cnt_ff[3:0] - 4'd1;
   assign fin_idx   = 3'(cnt_ff - 7'd1);
   assign pad_done  = !pad_first_ff && (fill_ff == 6'd56);
   assign put       = ((state_ff == ST_BYTE) && (bcnt_ff != nbytes_ff))
                   || ((state_ff == ST_PAD) && !pad_done);
   assign blk_full  = put && (fill_ff == 6'd63);
   assign put_byte  = (state_ff == ST_BYTE) ? msg_ff[5'(31 - 8 * bcnt_ff) -: 8]
                    : (pad_first_ff ? 8'h80 : 8'h00);
   assign pw_new    = ((fill_ff[1:0] == 2'd0) ? 32'd0 : pw_ff)
                    | ({24'd0, put_byte} << {~fill_ff[1:0], 3'b000});
   assign key_word  = (load_idx[0] ? key_ff[load_idx[3:1]][31:0]
                                   : key_ff[load_idx[3:1]][63:32])
                    ^ ((src_ff == SRC_IPAD) ? IPAD_WORD : OPAD_WORD);

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               state_in = pads_ff ? ST_BYTE : ST_C_INIT;
            end
         end
         ST_GO_OPAD:  state_in = ST_C_INIT;
         ST_BYTE: begin
            if (bcnt_ff == nbytes_ff) begin
               state_in = last_ff ? ST_PAD : ST_IDLE;
            end else if (blk_full) begin
               state_in = ST_C_INIT;
            end
         end
         ST_PAD: begin
            if (pad_done) begin
               state_in = ST_LEN_HI;
            end else if (blk_full) begin
               state_in = ST_C_INIT;
            end
         end
         ST_LEN_HI:   state_in = ST_LEN_LO;
         ST_LEN_LO:   state_in = ST_C_INIT;
         ST_GO_OUTER: state_in = ST_C_INIT;
         ST_C_INIT:   state_in = (cnt_ff == 7'd8) ? ST_C_LOAD : ST_C_INIT;
         ST_C_LOAD:   state_in = (cnt_ff == 7'd16) ? ST_C_ROUND : ST_C_LOAD;
         ST_C_ROUND:  state_in = (cnt_ff == 7'd63) ? ST_C_FINAL : ST_C_ROUND;
         ST_C_FINAL:  state_in = (cnt_ff == 7'd8) ? ret_ff : ST_C_FINAL;
         ST_OUT_RD:   state_in = ST_OUT_WAIT;
         ST_OUT_WAIT: begin
            if (rsp_ready) begin
               state_in = (cnt_ff[2:0] == 3'd7) ? ST_IDLE : ST_OUT_RD;
            end
         end
         default:     state_in = ST_IDLE;
      endcase
   end

   // Outputs, memory controls and register updates.
   always_comb begin
      ret_in       = ret_ff;
      src_in       = src_ff;
      src_reg_in   = src_reg_ff;
      dst_reg_in   = dst_reg_ff;
      use_iv_in    = use_iv_ff;
      cnt_in       = cnt_ff;
      bcnt_in      = bcnt_ff;
      nbytes_in    = nbytes_ff;
      last_in      = last_ff;
      msg_in       = msg_ff;
      pw_in        = pw_ff;
      fill_in      = fill_ff;
      len_in       = len_ff;
      pads_in      = pads_ff;
      fresh_in     = fresh_ff;
      pad_first_in = pad_first_ff;

      st_wr_en    = 1'b0;
      st_wr_addr  = {dst_reg_ff, fin_idx};
      st_wr_data  = (use_iv_ff ? iv_word(fin_idx) : st_rd_data) + a_val;
      st_rd_en    = 1'b0;
      st_rd_addr  = {src_reg_ff, cnt_ff[2:0]};
      buf_wr_en   = 1'b0;
      buf_wr_addr = fill_ff[5:2];
      buf_wr_data = pw_new;
      buf_rd_en   = 1'b0;
      buf_rd_addr = cnt_ff[3:0];

      ctrl           = '0;
      ctrl.round_idx = cnt_ff[5:0];
      ctrl.din       = use_iv_ff ? iv_word(fin_idx) : st_rd_data;

      if (csr_valid && (csr_index < 4'(KEY_REGS))) begin
         pads_in = 1'b0;
      end

      if (put) begin
         pw_in   = pw_new;
         fill_in = fill_ff + 6'd1;
         if (fill_ff[1:0] == 2'd3) begin
            buf_wr_en = 1'b1;
         end
      end

      // A full block hands the buffer to the compression unit.
      if (blk_full) begin
         src_in     = SRC_BUF;
         use_iv_in  = 1'b0;
         src_reg_in = fresh_ff ? REG_INNER : REG_CHAIN;
         dst_reg_in = REG_CHAIN;
         fresh_in   = 1'b0;
         ret_in     = state_ff;
         cnt_in     = 7'd0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               msg_in    = req_msg_word;
               nbytes_in = (req_valid_bytes > 3'd4) ? 3'd4 : req_valid_bytes;
               last_in   = req_last_word;
               bcnt_in   = 3'd0;
               if (!pads_ff) begin
                  src_in     = SRC_IPAD;
                  use_iv_in  = 1'b1;
                  dst_reg_in = REG_INNER;
                  ret_in     = ST_GO_OPAD;
                  cnt_in     = 7'd0;
                  pads_in    = 1'b1;
                  fresh_in   = 1'b1;
                  fill_in    = 6'd0;
                  len_in     = 64'd64;
               end
            end
         end
         ST_GO_OPAD: begin
            src_in     = SRC_OPAD;
            use_iv_in  = 1'b1;
            dst_reg_in = REG_OUTER;
            ret_in     = ST_BYTE;
            cnt_in     = 7'd0;
         end
         ST_BYTE: begin
            if (bcnt_ff == nbytes_ff) begin
               pad_first_in = 1'b1;
            end else begin
               bcnt_in = bcnt_ff + 3'd1;
               len_in  = len_ff + 64'd1;
            end
         end
         ST_PAD: begin
            if (put) begin
               pad_first_in = 1'b0;
            end
         end
         ST_LEN_HI: begin
            buf_wr_en   = 1'b1;
            buf_wr_addr = 4'd14;
            buf_wr_data = len_ff[60:29];
         end
         ST_LEN_LO: begin
            buf_wr_en   = 1'b1;
            buf_wr_addr = 4'd15;
            buf_wr_data = {len_ff[28:0], 3'b000};
            src_in      = SRC_BUF;
            use_iv_in   = 1'b0;
            src_reg_in  = fresh_ff ? REG_INNER : REG_CHAIN;
            dst_reg_in  = REG_CHAIN;
            fresh_in    = 1'b0;
            fill_in     = 6'd0;
            ret_in      = ST_GO_OUTER;
            cnt_in      = 7'd0;
         end
         ST_GO_OUTER: begin
            src_in     = SRC_OUTER;
            use_iv_in  = 1'b0;
            src_reg_in = REG_OUTER;
            dst_reg_in = REG_SCRATCH;
            ret_in     = ST_OUT_RD;
            cnt_in     = 7'd0;
         end
         ST_C_INIT: begin
            st_rd_en = !use_iv_ff && (cnt_ff < 7'd8);
            if (cnt_ff != 7'd0) begin
               ctrl.wk_shift = 1'b1;
            end
            cnt_in = (cnt_ff == 7'd8) ? 7'd0 : cnt_ff + 7'd1;
         end
         ST_C_LOAD: begin
            buf_rd_en  = (src_ff == SRC_BUF) && (cnt_ff < 7'd16);
            st_rd_en   = (src_ff == SRC_OUTER) && (cnt_ff < 7'd8);
            st_rd_addr = {REG_CHAIN, cnt_ff[2:0]};
            if (cnt_ff != 7'd0) begin
               ctrl.w_shift = 1'b1;
               case (src_ff)
                  SRC_BUF:  ctrl.din = buf_rd_data;
                  SRC_IPAD,
                  SRC_OPAD: ctrl.din = key_word;
                  default: begin
                     if (!load_idx[3]) begin
                        ctrl.din = st_rd_data;
                     end else if (load_idx == 4'd8) begin
                        ctrl.din = PAD_MARK;
                     end else if (load_idx == 4'd15) begin
                        ctrl.din = OUTER_BITS;
                     end else begin
                        ctrl.din = 32'd0;
                     end
                  end
               endcase
            end
            cnt_in = (cnt_ff == 7'd16) ? 7'd0 : cnt_ff + 7'd1;
         end
         ST_C_ROUND: begin
            ctrl.round = 1'b1;
            cnt_in     = (cnt_ff == 7'd63) ? 7'd0 : cnt_ff + 7'd1;
         end
         ST_C_FINAL: begin
            st_rd_en = !use_iv_ff && (cnt_ff < 7'd8);
            if (cnt_ff != 7'd0) begin
               st_wr_en      = 1'b1;
               ctrl.wk_shift = 1'b1;
            end
            cnt_in = (cnt_ff == 7'd8) ? 7'd0 : cnt_ff + 7'd1;
         end
         ST_OUT_RD: begin
            st_rd_en   = 1'b1;
            st_rd_addr = {REG_SCRATCH, cnt_ff[2:0]};
         end
         ST_OUT_WAIT: begin
            if (rsp_ready) begin
               if (cnt_ff[2:0] == 3'd7) begin
                  cnt_in   = 7'd0;
                  fresh_in = 1'b1;
                  fill_in  = 6'd0;
                  len_in   = 64'd64;
               end else begin
                  cnt_in = cnt_ff + 7'd1;
               end
            end
         end
         default: begin
         end
      endcase
   end

   assign rsp_valid        = (state_ff == ST_OUT_WAIT);
   assign rsp_digest_word  = st_rd_data;
   assign rsp_digest_index = cnt_ff[2:0];
   assign rsp_digest_last  = (cnt_ff[2:0] == 3'd7);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         ret_ff       <= ST_IDLE;
         cnt_ff       <= 7'd0;
         bcnt_ff      <= 3'd0;
         fill_ff      <= 6'd0;
         len_ff       <= 64'd0;
         pads_ff      <= 1'b0;
         fresh_ff     <= 1'b0;
         pad_first_ff <= 1'b0;
         for (int i = 0; i < KEY_REGS; i++) begin
            key_ff[i] <= 64'd0;
         end
      end else begin
         state_ff     <= state_in;
         ret_ff       <= ret_in;
         cnt_ff       <= cnt_in;
         bcnt_ff      <= bcnt_in;
         fill_ff      <= fill_in;
         len_ff       <= len_in;
         pads_ff      <= pads_in;
         fresh_ff     <= fresh_in;
         pad_first_ff <= pad_first_in;
         if (csr_valid && (csr_index < 4'(KEY_REGS))) begin
            key_ff[csr_index[2:0]] <= csr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      src_ff     <= src_in;
      src_reg_ff <= src_reg_in;
      dst_reg_ff <= dst_reg_in;
      use_iv_ff  <= use_iv_in;
      nbytes_ff  <= nbytes_in;
      last_ff    <= last_in;
      msg_ff     <= msg_in;
      pw_ff      <= pw_in;
   end

   hss_ram #(.WIDTH(32), .DEPTH(32)) u_state_ram (
      .clock   (clock),
      .wr_en   (st_wr_en),
      .wr_addr (st_wr_addr),
      .wr_data (st_wr_data),
      .rd_en   (st_rd_en),
      .rd_addr (st_rd_addr),
      .rd_data (st_rd_data)
   );

   hss_ram #(.WIDTH(32), .DEPTH(16)) u_block_ram (
      .clock   (clock),
      .wr_en   (buf_wr_en),
      .wr_addr (buf_wr_addr),
      .wr_data (buf_wr_data),
      .rd_en   (buf_rd_en),
      .rd_addr (buf_rd_addr),
      .rd_data (buf_rd_data)
   );

   hss_compress u_compress (
      .clock (clock),
      .ctrl  (ctrl),
      .a_val (a_val)
   );

endmodule
